// File: hdl/multibulk_request_parser_defines.svh
// Assertion macros shared by the parser RTL.
// Each expects clk and rst_n in scope.
`ifndef MULTIBULK_REQUEST_PARSER_DEFINES_SVH
`define MULTIBULK_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication.
`define MRP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mrp check failed");

// Next-cycle implication.
`define MRP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mrp check failed");

`endif

// File: hdl/mrp_pkg.sv
package mrp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COUNT,
        PH_LEN,
        PH_SKIP,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NESTED     = 3'd1;
    localparam logic [2:0] ERR_NO_COUNT   = 3'd2;
    localparam logic [2:0] ERR_ZERO       = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd5;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [9:0] arg_index;
        logic       arg_last;
        logic       command_last;
        logic [2:0] error_code;
    } mrp_result_t;

endpackage

// File: hdl/multibulk_request_parser.sv
// Multibulk request parser.
// Slave stream: one received request byte per transfer in s_axis_tdata.
// Master stream: one result per request byte. m_axis_tuser carries the kind
// (framing byte, argument payload byte, error); payload bytes come with their
// argument index, an argument-last flag in tdata and a command-last flag on
// tlast. Errors carry a code in tdata and stick until reset.
// A request accepted on the slave side passes the input register, then the
// result register, before its result shows on the master side.
// Throughput: one request per cycle while the receiver takes results, set by
// the single parse step between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready drops once both are occupied and returns in the cycle
// the receiver takes the result.
// Reset clears both stream stages, returns the parser to idle between
// segments with no command open, and clears any latched error.
module multibulk_request_parser #(
    parameter int MAX_ARGS    = 1024,
    parameter int MAX_ARG_LEN = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] arg_index,
                                        // [18] arg_last, [21:19] error_code
    output logic        m_axis_tlast,   // command_last
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import mrp_pkg::*;

    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        advance;
    mrp_result_t result;

    // move a request into the result register when it is free or being drained
    assign advance = byte_valid && (!out_valid || m_axis_tready);

    mrp_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .byte_valid    (byte_valid),
        .rx_byte       (rx_byte)
    );

    mrp_core #(
        .MAX_ARGS    (MAX_ARGS),
        .MAX_ARG_LEN (MAX_ARG_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (rx_byte),
        .result  (result)
    );

    mrp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .result        (result),
        .out_valid     (out_valid),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: hdl/mrp_in_stage.sv
module mrp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);
    import mrp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

// File: hdl/mrp_core.sv
`include "multibulk_request_parser_defines.svh"

module mrp_core #(
    parameter int MAX_ARGS    = 1024,
    parameter int MAX_ARG_LEN = 1048576
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    output mrp_pkg::mrp_result_t result
);
    import mrp_pkg::*;

    localparam int BOUND_MAX = (MAX_ARGS > MAX_ARG_LEN) ? MAX_ARGS : MAX_ARG_LEN;
    localparam int NUM_W     = $clog2(BOUND_MAX + 1);
    localparam int PROD_W    = NUM_W + 4;
    localparam int AE_W      = $clog2(MAX_ARGS + 1);
    localparam int AR_W      = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int LEN_W     = $clog2(MAX_ARG_LEN + 1);
    localparam logic [PROD_W-1:0] ARGS_BOUND = PROD_W'(MAX_ARGS);
    localparam logic [PROD_W-1:0] LEN_BOUND  = PROD_W'(MAX_ARG_LEN);

    phase_t             phase_reg,   phase_next;
    logic [NUM_W-1:0]   accum_reg,   accum_next;
    logic [AE_W-1:0]    args_exp_reg, args_exp_next;
    logic [AR_W-1:0]    args_rcv_reg, args_rcv_next;
    logic [LEN_W-1:0]   bytes_rem_reg, bytes_rem_next;
    logic [1:0]         skip_reg,    skip_next;
    logic [2:0]         err_reg,     err_next;

    logic               is_digit;
    logic [PROD_W-1:0]  accum_ext;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  bound;
    logic [2:0]         new_err;
    logic               arg_last;
    logic               cmd_last;
    logic [1:0]         skip_dec;

    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign accum_ext = PROD_W'(accum_reg);
    // times ten plus the digit
    assign prod      = (accum_ext << 3) + (accum_ext << 1) + PROD_W'(rx_byte[3:0]);
    assign bound     = (phase_reg == PH_COUNT) ? ARGS_BOUND : LEN_BOUND;
    assign arg_last  = (bytes_rem_reg <= LEN_W'(1));
    assign cmd_last  = arg_last &&
                       ((AE_W + 1)'(args_rcv_reg) + (AE_W + 1)'(1) >= (AE_W + 1)'(args_exp_reg));
    assign skip_dec  = (skip_reg != 2'd0) ? skip_reg - 2'd1 : 2'd0;

    // error raised by this byte
    always_comb
    begin
        new_err = ERR_NONE;
        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (rx_byte == CH_CR || rx_byte == CH_LF)
                begin
                    new_err = ERR_NONE;
                end
                else if (rx_byte == CH_STAR)
                begin
                    if (args_exp_reg != '0)
                    begin
                        new_err = ERR_NESTED;
                    end
                end
                else if (rx_byte == CH_DOLLAR)
                begin
                    if (args_exp_reg == '0)
                    begin
                        new_err = ERR_NO_COUNT;
                    end
                end
                else
                begin
                    new_err = ERR_UNEXPECTED;
                end
            end
            PH_COUNT, PH_LEN:
            begin
                if (is_digit)
                begin
                    if (prod > bound)
                    begin
                        new_err = ERR_TOO_LARGE;
                    end
                end
                else if (rx_byte == CH_CR)
                begin
                    if (accum_reg == '0)
                    begin
                        new_err = ERR_ZERO;
                    end
                end
                else
                begin
                    new_err = ERR_UNEXPECTED;
                end
            end
            PH_SKIP, PH_PAYLOAD, PH_ERROR:
            begin
                new_err = ERR_NONE;
            end
            default:
            begin
                new_err = ERR_UNEXPECTED;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        args_exp_next  = args_exp_reg;
        args_rcv_next  = args_rcv_reg;
        bytes_rem_next = bytes_rem_reg;
        skip_next      = skip_reg;
        err_next       = err_reg;
        if (err_reg != ERR_NONE)
        begin
            phase_next = PH_ERROR;
        end
        else if (new_err != ERR_NONE)
        begin
            err_next   = new_err;
            phase_next = PH_ERROR;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                    if (rx_byte == CH_STAR)
                    begin
                        accum_next = '0;
                        phase_next = PH_COUNT;
                    end
                    else if (rx_byte == CH_DOLLAR)
                    begin
                        accum_next = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_COUNT, PH_LEN:
                begin
                    if (is_digit)
                    begin
                        accum_next = prod[NUM_W-1:0];
                    end
                    else
                    begin
                        // CR ends a non-zero number
                        if (phase_reg == PH_COUNT)
                        begin
                            args_exp_next = AE_W'(accum_reg);
                            args_rcv_next = '0;
                        end
                        else
                        begin
                            bytes_rem_next = LEN_W'(accum_reg);
                        end
                        accum_next = '0;
                        skip_next  = 2'd1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 2'd0)
                    begin
                        phase_next = (bytes_rem_reg != '0) ? PH_PAYLOAD : PH_IDLE;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (arg_last)
                    begin
                        bytes_rem_next = '0;
                        if (cmd_last)
                        begin
                            args_exp_next = '0;
                            args_rcv_next = '0;
                        end
                        else
                        begin
                            args_rcv_next = args_rcv_reg + AR_W'(1);
                        end
                        skip_next  = 2'd2;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        bytes_rem_next = bytes_rem_reg - LEN_W'(1);
                    end
                end
                PH_ERROR:
                begin
                    phase_next = PH_ERROR;
                end
                default:
                begin
                    err_next   = ERR_UNEXPECTED;
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // result for this byte
    always_comb
    begin
        result = '0;
        if (err_reg != ERR_NONE)
        begin
            result.kind       = KIND_ERROR;
            result.error_code = err_reg;
        end
        else if (new_err != ERR_NONE)
        begin
            result.kind       = KIND_ERROR;
            result.error_code = new_err;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = rx_byte;
            result.arg_index    = 10'(args_rcv_reg);
            result.arg_last     = arg_last;
            result.command_last = cmd_last;
        end
        else
        begin
            result.kind = KIND_FRAME;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            args_exp_reg  <= '0;
            args_rcv_reg  <= '0;
            bytes_rem_reg <= '0;
            skip_reg      <= 2'd0;
            err_reg       <= ERR_NONE;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            args_exp_reg  <= args_exp_next;
            args_rcv_reg  <= args_rcv_next;
            bytes_rem_reg <= bytes_rem_next;
            skip_reg      <= skip_next;
            err_reg       <= err_next;
        end
    end

    `MRP_ASSERT_NXT(a_err_sticky, err_reg != ERR_NONE, err_reg == $past(err_reg))
    `MRP_ASSERT_IMP(a_payload_len, phase_reg == PH_PAYLOAD, bytes_rem_reg != '0)
    `MRP_ASSERT_IMP(a_payload_open, phase_reg == PH_PAYLOAD, args_exp_reg != '0)
    `MRP_ASSERT_IMP(a_rcv_below, args_exp_reg != '0,
                    (AE_W + 1)'(args_rcv_reg) < (AE_W + 1)'(args_exp_reg))
    `MRP_ASSERT_IMP(a_err_phase, (err_reg != ERR_NONE) || (phase_reg == PH_ERROR),
                    (err_reg != ERR_NONE) && (phase_reg == PH_ERROR))

endmodule

// File: hdl/mrp_out_stage.sv
module mrp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  mrp_pkg::mrp_result_t result,
    output logic                 out_valid,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // [7:0] payload_byte, [17:8] arg_index,
                                                // [18] arg_last, [21:19] error_code
    output logic                 m_axis_tlast,  // command_last
    output logic [1:0]           m_axis_tuser   // [1:0] kind
);
    import mrp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    mrp_result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign out_valid     = valid_reg;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, res_reg.error_code, res_reg.arg_last,
                            res_reg.arg_index, res_reg.payload_byte};
    assign m_axis_tlast  = res_reg.command_last;
    assign m_axis_tuser  = res_reg.kind;

endmodule
